FILE: rtl/core/spq_pkg.sv
// Package for the sorted priority queue: operation and status codes,
// and the structs passed between the top level and the storage cells.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Operation broadcast to every cell in the accepted cycle.
	typedef struct packed {
		logic               enq;
		logic               deq;
		logic signed [31:0] item;
		logic signed [31:0] prio;
	} cmd_t;

	// What a cell shows to its neighbors.
	typedef struct packed {
		logic               ge;
		logic signed [31:0] item;
		logic signed [31:0] prio;
	} link_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted priority queue: holds an item and its priority and
// loads from its upper neighbor, its lower neighbor or the new entry.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  wire logic          clk,
	input  wire cmd_t          cmd,
	input  wire logic [CW-1:0] count,
	input  wire link_t         prev,
	input  wire link_t         next,
	output link_t              cur
);

	logic signed [31:0] item_q;
	logic signed [31:0] prio_q;
	logic               occ;

	// Held priorities are sorted and held slots form a prefix, so the ge flags
	// form a prefix too: the new entry lands at the first cell whose flag drops.
	assign occ      = count > CW'(INDEX);
	assign cur.ge   = occ && !(prio_q < cmd.prio);
	assign cur.item = item_q;
	assign cur.prio = prio_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!prev.ge) begin
				item_q <= prev.item;
				prio_q <= prev.prio;
			end else if (!cur.ge) begin
				item_q <= cmd.item;
				prio_q <= cmd.prio;
			end
		end else if (cmd.deq) begin
			item_q <= next.item;
			prio_q <= next.prio;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: command decode, entry count,
// the row of storage cells and the result registers.
// Depends on spq_pkg and spq_cell.
//
// Usage: raise start with func, in_item and in_priority; the beat is taken
// at any edge where start is high and busy is low. busy stays low, so a new
// operation can be issued in every cycle. Each operation gives exactly one
// result in the next cycle: done is high for that single cycle with status,
// out_valid, out_item, out_priority and occupancy. Throughput is one
// operation per cycle; the whole row of cells compares against the new
// priority and shifts in parallel in the cycle the operation is taken.
// An enqueue on a full queue reports full and changes nothing; a dequeue on
// an empty queue reports empty and changes nothing. Equal priorities are
// served in arrival order. The receiver cannot stall: a result not taken in
// its cycle is lost. Reset empties the queue at once and clears done; the
// contents of the cells are not cleared, as only held slots are ever read.
`default_nettype none

module sorted_priority_queue_top import spq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               func,
	input  wire logic signed [31:0] in_item,
	input  wire logic signed [31:0] in_priority,
	output logic                    done,
	output logic [1:0]              status,
	output logic                    out_valid,
	output logic signed [31:0]      out_item,
	output logic signed [31:0]      out_priority,
	output logic [6:0]              occupancy
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          full;
	logic          empty;
	logic          take;
	cmd_t          cmd;
	link_t         head_lk;
	link_t         cell_lk [DEPTH];

	logic               done_q;
	logic [1:0]         status_q;
	logic               out_valid_q;
	logic signed [31:0] out_item_q;
	logic signed [31:0] out_priority_q;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;

	assign cmd.enq  = take && (func == FUNC_ENQ) && !full;
	assign cmd.deq  = take && (func == FUNC_DEQ) && !empty;
	assign cmd.item = in_item;
	assign cmd.prio = in_priority;

	// Above the head there is always room in front of the new entry.
	assign head_lk.ge   = 1'b1;
	assign head_lk.item = '0;
	assign head_lk.prio = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		link_t prev_lk;
		link_t next_lk;
		if (i == 0) begin : g_first
			assign prev_lk = head_lk;
		end else begin : g_mid
			assign prev_lk = cell_lk[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_lk = cell_lk[i];
		end else begin : g_inner
			assign next_lk = cell_lk[i+1];
		end
		spq_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.count(count_q),
			.prev (prev_lk),
			.next (next_lk),
			.cur  (cell_lk[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (cmd.enq) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.deq) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_valid_q <= cmd.deq;
			if (func == FUNC_ENQ) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_OK;
			end
			out_item_q     <= cmd.deq ? cell_lk[0].item : '0;
			out_priority_q <= cmd.deq ? cell_lk[0].prio : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;
	assign out_item     = out_item_q;
	assign out_priority = out_priority_q;
	assign occupancy    = 7'(count_q);

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("accepted beat did not produce a result");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not add one entry");
	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		(take && func == FUNC_DEQ && empty) |=> (status == ST_EMPTY && !out_valid))
		else $error("dequeue on empty queue misreported");
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> status == ST_OK)
		else $error("returned entry with error status");
`endif

endmodule

`default_nettype wire

FILE: bench/sorted_priority_queue_top_tb.sv
// Testbench for sorted_priority_queue_top: drives enqueue and dequeue commands,
// predicts every result in a scoreboard class and checks each done beat.
// Depends on spq_pkg and the sorted priority queue RTL.
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;
	import spq_pkg::*;

	localparam int QDEPTH      = 64;
	localparam int RANDOM_OPS  = 850;
	localparam int CYCLE_LIMIT = 100000;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

	typedef struct {
		logic [1:0]         status;
		logic               valid;
		logic signed [31:0] item;
		logic signed [31:0] prio;
		logic [6:0]         occ;
	} queue_result_t;

	// Holds its own copy of the queue contents and the results still owed.
	class spq_scoreboard;
		logic signed [31:0] held_item[$];
		logic signed [31:0] held_prio[$];
		queue_result_t      owed[$];
		int errors = 0;
		int n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0, n_checked = 0;

		function int pending();
			return owed.size();
		endfunction

		function void note_command(logic f, logic signed [31:0] it,
				logic signed [31:0] pr);
			queue_result_t r;
			int pos;
			r.status = ST_OK;
			r.valid  = 1'b0;
			r.item   = '0;
			r.prio   = '0;
			if (f == FUNC_ENQ) begin
				n_enq++;
				if (held_prio.size() >= QDEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					// A new entry goes behind every entry of equal or higher priority.
					pos = 0;
					while (pos < held_prio.size() && held_prio[pos] >= pr)
						pos++;
					held_item.insert(pos, it);
					held_prio.insert(pos, pr);
				end
			end else begin
				n_deq++;
				if (held_prio.size() == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					r.valid = 1'b1;
					r.item  = held_item.pop_front();
					r.prio  = held_prio.pop_front();
				end
			end
			r.occ = 7'(held_prio.size());
			owed.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
					$time, name, want, got);
			end
		endfunction

		function void check_result(logic [1:0] st, logic vld, logic signed [31:0] it,
				logic signed [31:0] pr, logic [6:0] occ);
			queue_result_t r;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, status %0d item 0x%h",
					$time, st, it);
			end else begin
				r = owed.pop_front();
				n_checked++;
				compare_field("status", 32'(r.status), 32'(st));
				compare_field("out_valid", 32'(r.valid), 32'(vld));
				compare_field("out_item", r.item, it);
				compare_field("out_priority", r.prio, pr);
				compare_field("occupancy", 32'(r.occ), 32'(occ));
			end
		endfunction

		function void flag_leftover();
			errors += owed.size();
			$display("%0t: %0d expected results never arrived", $time, owed.size());
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic signed [31:0] in_item;
	logic signed [31:0] in_priority;
	logic               done;
	logic [1:0]         status;
	logic               out_valid;
	logic signed [31:0] out_item;
	logic signed [31:0] out_priority;
	logic [6:0]         occupancy;

	spq_scoreboard sb;
	bit idling_on = 1'b1;
	int cycle_count = 0;

	sorted_priority_queue_top #(
		.DEPTH(QDEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.in_item     (in_item),
		.in_priority (in_priority),
		.done        (done),
		.status      (status),
		.out_valid   (out_valid),
		.out_item    (out_item),
		.out_priority(out_priority),
		.occupancy   (occupancy)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver cannot stall, so every done beat is checked as it appears.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, out_valid, out_item, out_priority, occupancy);
	end

	// Inputs change at the falling edge; a beat is taken at the rising edge
	// where start is high and busy is low.
	task automatic send_cmd(input logic f, input logic signed [31:0] it,
			input logic signed [31:0] pr);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < 13) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		func        <= f;
		in_item     <= it;
		in_priority <= pr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(f, it, pr);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mix of narrow priorities for ties, the extremes, and the full range.
	function automatic logic signed [31:0] pick_prio();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return $signed(32'($urandom_range(6))) - 3;
		else if (roll < 50)
			case ($urandom_range(3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sh0;
				default: return -32'sd1;
			endcase
		return $signed($urandom);
	endfunction

	initial begin
		int n_random;
		int k;
		int len;
		int deq_pct;
		phase_kind_t kind;

		sb          = new;
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = FUNC_ENQ;
		in_item     = '0;
		in_priority = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty dequeue, extreme values, ties at zero and at the top.
		send_cmd(FUNC_DEQ, 32'sh12345678, 32'sh0);
		send_cmd(FUNC_ENQ, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_cmd(FUNC_ENQ, 32'sh80000000, 32'sh80000000);
		send_cmd(FUNC_ENQ, 32'sh0, 32'sh0);
		send_cmd(FUNC_ENQ, -32'sd1, -32'sd1);
		send_cmd(FUNC_ENQ, 32'sd1, 32'sh0);
		send_cmd(FUNC_ENQ, 32'sd2, 32'sh0);
		send_cmd(FUNC_ENQ, 32'sd3, 32'sh7FFFFFFF);
		for (k = 0; k < 8; k++)
			send_cmd(FUNC_DEQ, $signed($urandom), $signed($urandom));
		send_cmd(FUNC_ENQ, 32'sh55AA55AA, 32'sh2AAAAAAA);
		send_cmd(FUNC_DEQ, 32'sh0, 32'sh0);

		// Fill past the top so full is reported, then drain past empty.
		n_random = 0;
		for (k = 0; k < QDEPTH + 6; k++) begin
			send_cmd(FUNC_ENQ, $signed($urandom), pick_prio());
			n_random++;
		end
		wait_drained();
		for (k = 0; k < QDEPTH + 6; k++) begin
			send_cmd(FUNC_DEQ, $signed($urandom), $signed($urandom));
			n_random++;
		end

		while (n_random < RANDOM_OPS) begin
			kind = phase_kind_t'($urandom_range(2));
			case (kind)
				PH_FILL:  begin len = $urandom_range(60, 110); deq_pct = 10; end
				PH_DRAIN: begin len = $urandom_range(40, 90);  deq_pct = 85; end
				default:  begin len = $urandom_range(20, 60);  deq_pct = 50; end
			endcase
			for (k = 0; k < len && n_random < RANDOM_OPS; k++) begin
				idling_on = !(n_random >= 350 && n_random < 500);
				if ($urandom_range(99) < deq_pct)
					send_cmd(FUNC_DEQ, $signed($urandom), $signed($urandom));
				else
					send_cmd(FUNC_ENQ, $signed($urandom), pick_prio());
				n_random++;
			end
			if ($urandom_range(3) == 0)
				wait_drained();
		end

		@(negedge clk);
		start <= 1'b0;
		for (k = 0; k < 100 && sb.pending() != 0; k++)
			@(posedge clk);
		if (sb.pending() != 0)
			sb.flag_leftover();
		repeat (4) @(posedge clk);

		$display("Ran %0d enqueues (%0d refused as full) and %0d dequeues (%0d refused as empty).",
			sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
		$display("Checked %0d result beats in %0d cycles.", sb.n_checked, cycle_count);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
